// ===== hw/rtl/gcdp_pkg.sv =====
package gcdp_pkg;

  // Field widths
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned ACC_W       = 31;
  localparam int unsigned FRAC_CNT_W  = 3;
  localparam int unsigned VALUE_W     = 48;
  localparam int unsigned FRAC_BITS   = 16;
  localparam int unsigned DIVIDEND_W  = ACC_W + FRAC_BITS;  // acc shifted into Q31.16
  localparam int unsigned DIVISOR_W   = 24;                 // holds 10^7

  localparam int unsigned MAX_FRACTION_DIGITS_DEF = 6;

  localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};

  // Characters of interest
  localparam logic [BYTE_W-1:0] CH_K     = 8'h6B;  // 'k'
  localparam logic [BYTE_W-1:0] CH_P     = 8'h70;  // 'p'
  localparam logic [BYTE_W-1:0] CH_I     = 8'h69;  // 'i'
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;  // '.'
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;  // '-'
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;  // '+'
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;  // ' '
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;  // '0'
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;  // '9'

  typedef enum logic [1:0] {
    TGT_NONE = 2'd0,
    TGT_PROP = 2'd1,
    TGT_INTG = 2'd2
  } target_e;

  typedef enum logic [2:0] {
    PH_SKIP  = 3'd0,
    PH_SIGNS = 3'd1,
    PH_INT   = 3'd2,
    PH_FRAC  = 3'd3,
    PH_DONE  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    ST_IDLE = 2'd0,
    ST_DIV  = 2'd1,
    ST_HOLD = 2'd2
  } ctrl_state_e;

  typedef struct packed {
    logic [BYTE_W-1:0] rx_byte;
    logic              end_of_message;
  } in_t;

  typedef struct packed {
    logic [1:0]                target_gain;
    logic signed [VALUE_W-1:0] gain_value;
    logic                      value_saturated;
  } out_t;

  // Parse result handed to the conversion sequencer at the last byte
  typedef struct packed {
    target_e               target;
    logic                  negative;
    logic                  overflow;
    logic [ACC_W-1:0]      acc;
    logic [FRAC_CNT_W-1:0] frac_cnt;
  } job_t;

  function automatic logic [DIVISOR_W-1:0] pow10(input logic [FRAC_CNT_W-1:0] idx);
    logic [DIVISOR_W-1:0] p;
    unique case (idx)
      3'd0: p = 24'd1;
      3'd1: p = 24'd10;
      3'd2: p = 24'd100;
      3'd3: p = 24'd1000;
      3'd4: p = 24'd10000;
      3'd5: p = 24'd100000;
      3'd6: p = 24'd1000000;
      3'd7: p = 24'd10000000;
    endcase
    return p;
  endfunction

endpackage

// ===== hw/rtl/gcdp_parser.sv =====
module gcdp_parser
  import gcdp_pkg::*;
#(
  parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [BYTE_W-1:0] byte_i,
  input  logic              last_i,
  output job_t              job_o
);

  localparam logic [FRAC_CNT_W-1:0] FracLimit = FRAC_CNT_W'(MAX_FRACTION_DIGITS);

  logic [1:0]            pos_q, pos_d;
  logic [BYTE_W-1:0]     ch0_q, ch0_d, ch1_q, ch1_d;
  phase_e                ph_q, ph_d;
  logic                  neg_q, neg_d;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [FRAC_CNT_W-1:0] frac_q, frac_d;
  logic                  ovf_q, ovf_d;

  logic                  is_dig, is_sign;
  logic [3:0]            dig;
  logic [ACC_W+3:0]      mac;
  logic                  mac_sat;
  logic [ACC_W-1:0]      acc_acc;

  // Character classes
  assign is_dig  = (byte_i >= CH_ZERO) && (byte_i <= CH_NINE);
  assign is_sign = (byte_i == CH_SPACE) || (byte_i == CH_MINUS) || (byte_i == CH_PLUS);
  assign dig     = byte_i[3:0];

  // acc*10 + digit by shift-add, saturating
  assign mac     = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {{ACC_W{1'b0}}, dig};
  assign mac_sat = mac > {4'b0, ACC_MAX};
  assign acc_acc = mac_sat ? ACC_MAX : mac[ACC_W-1:0];

  always_comb begin
    pos_d  = pos_q;
    ch0_d  = ch0_q;
    ch1_d  = ch1_q;
    ph_d   = ph_q;
    neg_d  = neg_q;
    acc_d  = acc_q;
    frac_d = frac_q;
    ovf_d  = ovf_q;

    if (accept_i) begin
      // command letters
      if (pos_q == 2'd0) begin
        ch0_d = byte_i;
      end else if (pos_q == 2'd1) begin
        ch1_d = byte_i;
      end
      if (pos_q != 2'd2) begin
        pos_d = pos_q + 2'd1;
      end

      // number scan
      unique case (ph_q)
        PH_SKIP: begin
          if (is_dig) begin
            ph_d  = PH_INT;
            acc_d = acc_acc;
            ovf_d = ovf_q | mac_sat;
          end else if (is_sign) begin
            ph_d = PH_SIGNS;
            if (byte_i == CH_MINUS) neg_d = 1'b1;
          end
        end
        PH_SIGNS: begin
          if (is_sign) begin
            if (byte_i == CH_MINUS) neg_d = 1'b1;
          end else if (is_dig) begin
            ph_d  = PH_INT;
            acc_d = acc_acc;
            ovf_d = ovf_q | mac_sat;
          end else if (byte_i == CH_DOT) begin
            ph_d = PH_FRAC;
          end else begin
            ph_d = PH_DONE;
          end
        end
        PH_INT: begin
          if (is_dig) begin
            acc_d = acc_acc;
            ovf_d = ovf_q | mac_sat;
          end else if (byte_i == CH_DOT) begin
            ph_d = PH_FRAC;
          end else begin
            ph_d = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            if (frac_q < FracLimit) begin
              acc_d  = acc_acc;
              ovf_d  = ovf_q | mac_sat;
              frac_d = frac_q + FRAC_CNT_W'(1);
            end else begin
              ovf_d = 1'b1;  // excess fraction digit dropped
            end
          end else begin
            ph_d = PH_DONE;
          end
        end
        default: ;  // done: ignore bytes
      endcase
    end

    // snapshot of the updated state for the conversion
    if ((ch0_d == CH_K) && (ch1_d == CH_P)) begin
      job_o.target = TGT_PROP;
    end else if ((ch0_d == CH_K) && (ch1_d == CH_I)) begin
      job_o.target = TGT_INTG;
    end else begin
      job_o.target = TGT_NONE;
    end
    job_o.negative = neg_d;
    job_o.overflow = ovf_d;
    job_o.acc      = acc_d;
    job_o.frac_cnt = frac_d;

    // message ends: back to reset values
    if (accept_i && last_i) begin
      pos_d  = 2'd0;
      ch0_d  = '0;
      ch1_d  = '0;
      ph_d   = PH_SKIP;
      neg_d  = 1'b0;
      acc_d  = '0;
      frac_d = '0;
      ovf_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= 2'd0;
      ch0_q  <= '0;
      ch1_q  <= '0;
      ph_q   <= PH_SKIP;
      neg_q  <= 1'b0;
      acc_q  <= '0;
      frac_q <= '0;
      ovf_q  <= 1'b0;
    end else begin
      pos_q  <= pos_d;
      ch0_q  <= ch0_d;
      ch1_q  <= ch1_d;
      ph_q   <= ph_d;
      neg_q  <= neg_d;
      acc_q  <= acc_d;
      frac_q <= frac_d;
      ovf_q  <= ovf_d;
    end
  end

endmodule

// ===== hw/rtl/gcdp_divider.sv =====
module gcdp_divider
  import gcdp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic [DIVIDEND_W-1:0] dividend_i,
  input  logic [DIVISOR_W-1:0]  divisor_i,
  output logic                  done_o,
  output logic [DIVIDEND_W-1:0] quotient_o
);

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);
  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DIVIDEND_W - 1);

  logic                  run_q, run_d;
  logic                  done_q, done_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [DIVISOR_W-1:0]  rem_q, rem_d;
  logic [DIVISOR_W-1:0]  dsr_q, dsr_d;
  logic [DIVIDEND_W-1:0] quo_q, quo_d;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W+1:0]  diff;
  logic                  fits;

  // one restoring step: dividend bits shift out the top, quotient bits in
  assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
  assign diff  = {1'b0, trial} - {2'b0, dsr_q};
  assign fits  = !diff[DIVISOR_W+1];

  always_comb begin
    run_d  = run_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    if (start_i) begin
      run_d = 1'b1;
      cnt_d = '0;
      rem_d = '0;
      dsr_d = divisor_i;
      quo_d = dividend_i;
    end else if (run_q) begin
      rem_d = fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
      quo_d = {quo_q[DIVIDEND_W-2:0], fits};
      cnt_d = cnt_q + CNT_W'(1);
      if (cnt_q == LastStep) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// ===== hw/rtl/gain_command_decimal_parser.sv =====
// Gain command parser: ASCII bytes in, target and signed Q32.16 value out.
// Bytes of a message are taken back to back. The last byte starts a
// restoring divide by 10^fraction_digits, one quotient bit per cycle;
// the quotient is registered at the output once the output slot is free.
// Input stalls during the divide and while an older result still waits.
// Asynchronous active-low reset clears parse state and the output valid.
module gain_command_decimal_parser
  import gcdp_pkg::*;
#(
  parameter int unsigned MAX_FRACTION_DIGITS = MAX_FRACTION_DIGITS_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  ctrl_state_e state_q, state_d;

  logic in_acc, msg_end;
  job_t job;

  logic                  div_done;
  logic [DIVIDEND_W-1:0] quotient;

  target_e tgt_q;
  logic    neg_q, ovf_q;

  logic       out_valid_q, out_valid_d;
  logic       out_load, slot_free;
  out_t       out_q;
  logic [VALUE_W-1:0] mag;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign msg_end    = in_acc && in_data_i.end_of_message;
  assign slot_free  = !out_valid_q || !out_stall_i;

  gcdp_parser #(
    .MAX_FRACTION_DIGITS(MAX_FRACTION_DIGITS)
  ) u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_acc),
    .byte_i   (in_data_i.rx_byte),
    .last_i   (in_data_i.end_of_message),
    .job_o    (job)
  );

  gcdp_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (msg_end),
    .dividend_i ({job.acc, {FRAC_BITS{1'b0}}}),
    .divisor_i  (pow10(job.frac_cnt)),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // sequencer
  always_comb begin
    state_d  = state_q;
    out_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (msg_end) state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          if (slot_free) begin
            out_load = 1'b1;
            state_d  = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // job side info held over the divide
  always_ff @(posedge clk_i) begin
    if (msg_end) begin
      tgt_q <= job.target;
      neg_q <= job.negative;
      ovf_q <= job.overflow;
    end
  end

  // sign applied to the magnitude, modulo 2^48
  assign mag = {{(VALUE_W-DIVIDEND_W){1'b0}}, quotient};

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q.target_gain     <= tgt_q;
      out_q.gain_value      <= neg_q ? (~mag + VALUE_W'(1)) : mag;
      out_q.value_saturated <= ovf_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ===== tb/gain_command_decimal_parser_test.sv =====
`timescale 1ns / 100ps

module gain_command_decimal_parser_test
  import gcdp_pkg::*;
;

  localparam int unsigned FRAC_LIMIT  = MAX_FRACTION_DIGITS_DEF;
  localparam int unsigned ITEM_TARGET = 1400;
  localparam int unsigned MAX_WAIT    = 17;
  localparam int unsigned SETTLE      = 64;      // wait after the drain for stray results
  localparam int unsigned CYCLE_LIMIT = 600000;

  // Tracks parser state per byte and holds the gain updates still due
  class gain_scoreboard;
    logic [1:0]       pos;
    logic [7:0]       first_ch;
    logic [7:0]       second_ch;
    phase_e           phase;
    logic             neg;
    logic [ACC_W-1:0] acc;
    logic [2:0]       frac_cnt;
    logic             ovf;
    out_t             expected_q[$];
    int unsigned      errors;
    int unsigned      checked;
    int unsigned      saturated;
    int unsigned      negatives;

    function void clear();
      pos       = '0;
      first_ch  = '0;
      second_ch = '0;
      phase     = PH_SKIP;
      neg       = 1'b0;
      acc       = '0;
      frac_cnt  = '0;
      ovf       = 1'b0;
    endfunction

    function bit is_digit(logic [7:0] c);
      return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function bit is_sign(logic [7:0] c);
      return c == CH_SPACE || c == CH_MINUS || c == CH_PLUS;
    endfunction

    // acc*10 + digit, clamped at the accumulator maximum
    function void add_digit(logic [7:0] c);
      logic [63:0] v;
      v = 64'(acc) * 64'd10 + 64'(c) - 64'(CH_ZERO);
      if (v > 64'(ACC_MAX)) begin
        v   = 64'(ACC_MAX);
        ovf = 1'b1;
      end
      acc = v[ACC_W-1:0];
    endfunction

    function void advance_phase(logic [7:0] c);
      case (phase)
        PH_SKIP: begin
          if (is_digit(c)) begin
            phase = PH_INT;
            add_digit(c);
          end else if (is_sign(c)) begin
            phase = PH_SIGNS;
            if (c == CH_MINUS) neg = 1'b1;
          end
        end
        PH_SIGNS: begin
          if (is_sign(c)) begin
            if (c == CH_MINUS) neg = 1'b1;
          end else if (is_digit(c)) begin
            phase = PH_INT;
            add_digit(c);
          end else if (c == CH_DOT) begin
            phase = PH_FRAC;
          end else begin
            phase = PH_DONE;
          end
        end
        PH_INT: begin
          if (is_digit(c)) add_digit(c);
          else if (c == CH_DOT) phase = PH_FRAC;
          else phase = PH_DONE;
        end
        PH_FRAC: begin
          if (is_digit(c)) begin
            if (frac_cnt < FRAC_LIMIT) begin
              add_digit(c);
              frac_cnt = frac_cnt + 3'd1;
            end else begin
              ovf = 1'b1;  // digits past the limit are dropped
            end
          end else begin
            phase = PH_DONE;
          end
        end
        default: ;
      endcase
    endfunction

    // Called once per accepted input transaction
    function void note_input(in_t item);
      logic [63:0] divisor;
      logic [63:0] mag;
      logic [63:0] val;
      out_t        exp;
      int          k;
      if (pos == 2'd0) first_ch = item.rx_byte;
      else if (pos == 2'd1) second_ch = item.rx_byte;
      if (pos < 2'd2) pos = pos + 2'd1;
      advance_phase(item.rx_byte);
      if (item.end_of_message) begin
        exp.target_gain = TGT_NONE;
        if (first_ch == CH_K && second_ch == CH_P) exp.target_gain = TGT_PROP;
        else if (first_ch == CH_K && second_ch == CH_I) exp.target_gain = TGT_INTG;
        divisor = 64'd1;
        for (k = 0; k < frac_cnt; k++) divisor = divisor * 64'd10;
        mag = (64'(acc) << FRAC_BITS) / divisor;
        val = neg ? 64'd0 - mag : mag;
        exp.gain_value      = val[VALUE_W-1:0];
        exp.value_saturated = ovf;
        if (ovf) saturated++;
        if (neg) negatives++;
        expected_q.push_back(exp);
        clear();
      end
    endfunction

    task report(string line);
      $display("ERROR @%0t: %s", $realtime, line);
      errors++;
    endtask

    // Called once per accepted output transaction
    task check_result(out_t got);
      out_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result target=%0d value=%0d sat=%0b",
                         got.target_gain, $signed(got.gain_value), got.value_saturated));
        return;
      end
      exp = expected_q.pop_front();
      checked++;
      if (got.target_gain !== exp.target_gain)
        report($sformatf("result %0d target_gain got %0d expected %0d",
                         checked, got.target_gain, exp.target_gain));
      if (got.gain_value !== exp.gain_value)
        report($sformatf("result %0d gain_value got %0d expected %0d",
                         checked, $signed(got.gain_value), $signed(exp.gain_value)));
      if (got.value_saturated !== exp.value_saturated)
        report($sformatf("result %0d value_saturated got %0b expected %0b",
                         checked, got.value_saturated, exp.value_saturated));
    endtask
  endclass

  logic        clk;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_t         in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_t        out_data;

  gain_scoreboard parser_sb;
  int unsigned    cycle_count = 0;
  int unsigned    bytes_sent  = 0;
  int unsigned    messages    = 0;
  bit             tx_steady   = 1'b0;
  bit             rx_steady   = 1'b0;

  gain_command_decimal_parser #(
    .MAX_FRACTION_DIGITS(FRAC_LIMIT)
  ) i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Run guard
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("Timed out after %0d cycles", cycle_count);
    $display("FAIL");
    $finish;
  end

  // One byte transaction; valid stays high after acceptance so that a
  // zero gap gives back-to-back bytes
  task automatic send_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    in_t         item;
    gap                 = tx_steady ? 0 : $urandom_range(0, MAX_WAIT);
    item.rx_byte        = b;
    item.end_of_message = last;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    parser_sb.note_input(item);
    bytes_sent++;
    if (last) messages++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  // Hold the sender until every pending gain update is out
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (parser_sb.expected_q.size() != 0);
  endtask

  // Result side: stall each result for a random time, possibly none, raising the stall before it shows up
  initial begin
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      hold = rx_steady ? 0 : $urandom_range(0, MAX_WAIT);
      out_stall <= (hold != 0);
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      if (hold != 0) begin
        repeat (hold - 1) @(posedge clk);
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
      parser_sb.check_result(out_data);
      if ($urandom_range(0, 7) == 0) rx_steady = !rx_steady;
    end
  end

  // Stimulus
  initial begin
    logic [7:0]  msg[$];
    int unsigned kind;
    int unsigned n;
    int unsigned drain;
    parser_sb = new;
    parser_sb.clear();
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: both targets, negative fraction, sign run and digit then junk,
    // a one-byte message of NUL, junk with a lone dot, dropped fraction digits
    send_text("kp-1.5");
    send_text("ki+-7x9");
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(CH_DOT, 1'b1);
    send_text("-.1234567");
    wait_drained();

    // Random messages, mostly well formed with random content
    while (bytes_sent < ITEM_TARGET) begin
      msg.delete();
      kind = $urandom_range(0, 9);
      if (kind < 2) begin
        n = $urandom_range(1, 6);
        repeat (n) msg.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 4))
          0, 1: begin msg.push_back(CH_K); msg.push_back(CH_P); end
          2: begin msg.push_back(CH_K); msg.push_back(CH_I); end
          3: begin msg.push_back(CH_K); msg.push_back(8'($urandom_range(0, 255))); end
          default: begin
            msg.push_back(8'($urandom_range(0, 255)));
            msg.push_back(8'($urandom_range(0, 255)));
          end
        endcase
        repeat ($urandom_range(0, 2)) msg.push_back(8'($urandom_range(8'h3A, 8'h7E)));
        repeat ($urandom_range(0, 3)) begin
          case ($urandom_range(0, 2))
            0: msg.push_back(CH_SPACE);
            1: msg.push_back(CH_MINUS);
            default: msg.push_back(CH_PLUS);
          endcase
        end
        // long digit runs can drive the accumulator into saturation
        n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4);
        repeat (n) msg.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        if ($urandom_range(0, 2) != 0) begin
          msg.push_back(CH_DOT);
          repeat ($urandom_range(0, 8)) msg.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
        end
        if ($urandom_range(0, 3) == 0) msg.push_back(8'($urandom_range(0, 255)));
        // cut short now and then
        if (kind == 2) msg = msg[0:$urandom_range(0, msg.size() - 1)];
      end
      foreach (msg[i]) send_byte(msg[i], i == msg.size() - 1);
      if ($urandom_range(0, 29) == 0) wait_drained();
      if ($urandom_range(0, 7) == 0) tx_steady = !tx_steady;
    end

    // Drain, then leave room for anything stray to show up
    in_valid <= 1'b0;
    drain = 0;
    do begin
      @(posedge clk);
      drain++;
    end while (parser_sb.expected_q.size() != 0 && drain < 5000);
    repeat (SETTLE) @(posedge clk);
    if (parser_sb.expected_q.size() != 0)
      parser_sb.report($sformatf("%0d gain updates never delivered",
                                 parser_sb.expected_q.size()));

    $display("Sent %0d bytes in %0d messages over %0d cycles; checked %0d gain updates,",
             bytes_sent, messages, cycle_count, parser_sb.checked);
    $display("%0d of them saturated and %0d carrying a minus sign; %0d mismatches.",
             parser_sb.saturated, parser_sb.negatives, parser_sb.errors);
    if (parser_sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
